### hw/rtl/tlii_pkg.sv
// ----------------------------------------------------------------------------
// tlii_pkg
// Shared constants, record types and character codes for the line indent
// indexer.
// ----------------------------------------------------------------------------
package tlii_pkg;

  localparam longint MaxSourceBytes = 64'd1048576;
  localparam int     TabStop        = 4;

  localparam int PosW = $clog2(MaxSourceBytes + 2);
  localparam int ColW = $clog2(TabStop * MaxSourceBytes + 1);
  localparam int TabW = $clog2(TabStop);

  localparam logic [PosW-1:0] MaxPos = PosW'(MaxSourceBytes);
  localparam logic [ColW:0]   MaxCol = (ColW + 1)'(TabStop * MaxSourceBytes);

  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [PosW-1:0] line_begin;
    logic [PosW-1:0] line_end;
    logic [PosW-1:0] indent_chars;
    logic [ColW-1:0] indent_columns;
    logic            is_sentinel;
    logic            overflow;
  } rec_t;

  typedef struct packed {
    logic [1:0] cnt;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

endpackage

### hw/rtl/text_line_indent_indexer.sv
// A record is stored in the queue when its byte is taken and is output from the head.
// Throughput: one byte per cycle; the final byte yields the sentinel, preceded
// by a line record unless it is leading whitespace; a four-entry queue drains one
// word per cycle while out_ready_i is high; input waits for two free entries.
// Reset: asynchronous, active low; clears scan state and empties the queue.
// ----------------------------------------------------------------------------
// text_line_indent_indexer
// Top level: scanner front end and record queue for per-line indent records.
// ----------------------------------------------------------------------------
module text_line_indent_indexer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  text_byte_i,
  input  logic                        final_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tlii_pkg::PosW-1:0]   line_begin_o,
  output logic [tlii_pkg::PosW-1:0]   line_end_o,
  output logic [tlii_pkg::PosW-1:0]   indent_chars_o,
  output logic [tlii_pkg::ColW-1:0]   indent_columns_o,
  output logic                        is_sentinel_o,
  output logic                        overflow_o
);
  import tlii_pkg::*;

  push_t push;
  logic  space_ok;
  rec_t  head;

  tlii_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .text_byte_i  (text_byte_i),
    .final_byte_i (final_byte_i),
    .space_ok_i   (space_ok),
    .in_ready_o   (in_ready_o),
    .push_o       (push)
  );

  tlii_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign line_begin_o     = head.line_begin;
  assign line_end_o       = head.line_end;
  assign indent_chars_o   = head.indent_chars;
  assign indent_columns_o = head.indent_columns;
  assign is_sentinel_o    = head.is_sentinel;
  assign overflow_o       = head.overflow;

endmodule

### hw/rtl/tlii_front.sv
// ----------------------------------------------------------------------------
// tlii_front
// Scanner: takes one byte per cycle while the queue has room, tracks line
// indent state and hands zero, one or two records to the queue.
// ----------------------------------------------------------------------------
module tlii_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [7:0]           text_byte_i,
  input  logic                 final_byte_i,
  input  logic                 space_ok_i,
  output logic                 in_ready_o,
  output tlii_pkg::push_t      push_o
);
  import tlii_pkg::*;

  logic [PosW-1:0] bpos_q, bpos_d;
  logic [PosW-1:0] start_q, start_d;
  logic [PosW-1:0] ind_q, ind_d;
  logic [ColW-1:0] col_q, col_d;
  logic            done_q, done_d;
  logic            sat_q, sat_d;

  logic            acc;
  logic            at_max;
  logic [PosW-1:0] pos;
  logic            sat;
  logic            is_ws;
  logic            is_nl;
  logic            line_rec;
  logic [PosW-1:0] line_end;
  logic [PosW-1:0] bpos_nxt;
  logic [ColW:0]   col_nxt;
  rec_t            line_r;
  rec_t            sent_r;

  assign in_ready_o = space_ok_i;
  assign acc        = in_valid_i & space_ok_i;

  always_comb begin
    at_max   = (bpos_q >= MaxPos);
    pos      = at_max ? MaxPos : bpos_q;
    sat      = sat_q | at_max;
    is_ws    = (text_byte_i == ChSpace) || (text_byte_i == ChTab);
    is_nl    = (text_byte_i == ChNewline);
    bpos_nxt = (pos < MaxPos) ? pos + 1'b1 : MaxPos;

    if (text_byte_i == ChTab) begin
      col_nxt = (({1'b0, col_q} >> TabW) + 1'b1) << TabW;
    end else begin
      col_nxt = {1'b0, col_q} + 1'b1;
    end
    if (col_nxt > MaxCol) begin
      col_nxt = MaxCol;
    end

    line_rec = 1'b0;
    line_end = pos;
    if (!is_nl && (pos < MaxPos)) begin
      line_end = pos + 1'b1;
    end

    start_d = start_q;
    ind_d   = ind_q;
    col_d   = col_q;
    done_d  = done_q;
    sat_d   = sat;
    bpos_d  = bpos_nxt;

    if (!done_q && is_ws) begin
      if (ind_q < MaxPos) begin
        ind_d = ind_q + 1'b1;
      end
      col_d = col_nxt[ColW-1:0];
    end else begin
      done_d = 1'b1;
      if (is_nl || final_byte_i) begin
        line_rec = 1'b1;
        done_d   = 1'b0;
        ind_d    = '0;
        col_d    = '0;
        start_d  = line_end + 1'b1;
      end
    end

    if (final_byte_i) begin
      bpos_d  = '0;
      start_d = '0;
      ind_d   = '0;
      col_d   = '0;
      done_d  = 1'b0;
      sat_d   = 1'b0;
    end
  end

  always_comb begin
    line_r.line_begin     = start_q;
    line_r.line_end       = line_end;
    line_r.indent_chars   = ind_q;
    line_r.indent_columns = col_q;
    line_r.is_sentinel    = 1'b0;
    line_r.overflow       = sat;

    sent_r.line_begin     = bpos_nxt;
    sent_r.line_end       = bpos_nxt;
    sent_r.indent_chars   = '0;
    sent_r.indent_columns = '0;
    sent_r.is_sentinel    = 1'b1;
    sent_r.overflow       = sat;

    push_o.rec0 = line_rec ? line_r : sent_r;
    push_o.rec1 = sent_r;
    push_o.cnt  = acc ? ({1'b0, line_rec} + {1'b0, final_byte_i}) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpos_q  <= '0;
      start_q <= '0;
      ind_q   <= '0;
      col_q   <= '0;
      done_q  <= 1'b0;
      sat_q   <= 1'b0;
    end else if (acc) begin
      bpos_q  <= bpos_d;
      start_q <= start_d;
      ind_q   <= ind_d;
      col_q   <= col_d;
      done_q  <= done_d;
      sat_q   <= sat_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_two_ends_sentinel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.cnt == 2'd2) |-> (push_o.rec1.is_sentinel && !push_o.rec0.is_sentinel))
    else $error("double push without trailing sentinel");
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && final_byte_i) |=> (bpos_q == '0 && !sat_q && !done_q))
    else $error("state not cleared after final byte");
  a_cols_cover_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} >= (ColW + 1)'(ind_q)))
    else $error("indent columns below indent count");
`endif

endmodule

### hw/rtl/tlii_queue.sv
// ----------------------------------------------------------------------------
// tlii_queue
// Record queue: takes up to two records per cycle from the scanner and
// presents one word per cycle on the output channel while out_ready_i is high.
// ----------------------------------------------------------------------------
module tlii_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tlii_pkg::push_t push_i,
  output logic            space_ok_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tlii_pkg::rec_t  head_o
);
  import tlii_pkg::*;

  rec_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;
  logic [QPtrW-1:0] wr_nxt;

  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];
  assign space_ok_o  = (cnt_q <= QCntW'(QDepth - 2));
  assign pop         = out_valid_o & out_ready_i;
  assign wr_nxt      = wr_q + 1'b1;

  always_comb begin
    wr_d  = wr_q + QPtrW'(push_i.cnt);
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCntW'(push_i.cnt) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.rec0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nxt] <= push_i.rec1;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count beyond depth");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    QCntW'(push_i.cnt) <= QCntW'(QDepth) - cnt_q)
    else $error("push beyond free space");
  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.cnt == 2'd0) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("count did not drop on pop");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != QCntW'(QDepth)) |-> (QPtrW'(wr_q - rd_q) == cnt_q[QPtrW-1:0]))
    else $error("pointers disagree with count");
`endif

endmodule
